// ===== hw/rtl/dpe_pkg.sv =====
// Shared types and constants for the decimal PIN entry block.
`timescale 1ns / 1ps

package dpe_pkg;

	// Width of one stored decimal digit and of the converted value.
	localparam int DIGIT_W = 4;
	localparam int VALUE_W = 64;

	// Keystroke codes of interest.
	localparam logic [7:0] KEY_BS   = 8'h08;
	localparam logic [7:0] KEY_LF   = 8'h0A;
	localparam logic [7:0] KEY_CR   = 8'h0D;
	localparam logic [7:0] KEY_ZERO = 8'h30;
	localparam logic [7:0] KEY_NINE = 8'h39;
	localparam logic [7:0] KEY_DEL  = 8'h7F;

	// Echo action codes.
	localparam logic [1:0] ECHO_NONE  = 2'd0;
	localparam logic [1:0] ECHO_MASK  = 2'd1;
	localparam logic [1:0] ECHO_ERASE = 2'd2;

	// Control of the multiply-by-ten accumulator.
	typedef struct packed {
		logic clear;
		logic step;
		logic first;
	} dpe_conv_ctl_t;

endpackage

// ===== hw/rtl/decimal_pin_entry_top.sv =====
// Top level of the decimal PIN entry block: key decode, digit store and sequencer.
`timescale 1ns / 1ps

// Each input beat is one keystroke or an end-of-input mark, and each gives exactly one
// result beat. Digits, backspace, DEL and ignored bytes go straight to the result register.
// A newline, carriage return or end of input with stored digits and no over-limit digits
// passes the prime, convert and done states: the multiply-by-ten adder folds in one digit
// per cycle, fed from the registered read port of the digit store. An empty entry, or one
// with over-limit digits left, skips the conversion. Input is not taken while a conversion
// runs or while the result register holds a beat that the output side has not taken. The
// digit store needs no clearing pass after reset. echo_enable resets to 1; the user must
// write it via cfg_we and cfg_wdata only while the block is idle; the block does not enforce it.
module decimal_pin_entry_top
	import dpe_pkg::*;
#(
	parameter int MAX_DIGITS          = 20,
	parameter int OVERFLOW_COUNT_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         key_byte,
	input  logic               end_of_input,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         echo_action,
	output logic               entry_done,
	output logic               pin_valid,
	output logic [VALUE_W-1:0] pin_value
);

	localparam int CNT_W = $clog2(MAX_DIGITS + 1);
	localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int OVF_W = OVERFLOW_COUNT_BITS;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DIGITS);

	// Sequencer states.
	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_PRIME = 2'd1;
	localparam logic [1:0] S_CONV  = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	logic [1:0]         state_q;
	logic               echo_en_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [OVF_W-1:0]   ovf_q;
	logic [CNT_W-1:0]   len_q;
	logic [CNT_W-1:0]   rd_idx_q;
	logic [CNT_W-1:0]   num_q;
	logic [DIGIT_W-1:0] mem [MAX_DIGITS];
	logic [DIGIT_W-1:0] rd_q;
	logic [IDX_W-1:0]   rd_addr;

	logic               out_v_q;
	logic [1:0]         echo_q;
	logic               done_q;
	logic               pvalid_q;
	logic [VALUE_W-1:0] value_q;

	logic               accept;
	logic               out_free;
	logic               is_term;
	logic               is_digit;
	logic               is_bs;
	logic               start_conv;
	logic [7:0]         key_off;
	logic [DIGIT_W-1:0] key_digit;
	dpe_conv_ctl_t      conv_ctl;
	logic [VALUE_W-1:0] conv_acc;
	logic               conv_bad;

	// Keystroke decode.
	always_comb begin
		is_term  = end_of_input || key_byte == KEY_LF || key_byte == KEY_CR;
		is_digit = !is_term && (key_byte inside {[KEY_ZERO:KEY_NINE]});
		is_bs    = !is_term && (key_byte inside {KEY_BS, KEY_DEL});
		key_off  = key_byte - KEY_ZERO;
		key_digit = key_off[DIGIT_W-1:0];
	end

	assign out_free   = !out_v_q || out_ready;
	assign in_ready   = (state_q == S_IDLE) && out_free;
	assign accept     = in_valid && in_ready;
	assign start_conv = accept && is_term && cnt_q != '0 && ovf_q == '0;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_en_q <= 1'b1;
		end else if (cfg_we) begin
			echo_en_q <= cfg_wdata;
		end
	end

	// Digit count and saturating over-limit count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= '0;
		end else if (accept) begin
			if (is_term) begin
				cnt_q <= '0;
				ovf_q <= '0;
			end else if (is_digit) begin
				if (cnt_q >= CNT_MAX) begin
					if (ovf_q != '1) begin
						ovf_q <= ovf_q + 1'b1;
					end
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end else if (is_bs) begin
				if (ovf_q != '0) begin
					ovf_q <= ovf_q - 1'b1;
				end else if (cnt_q != '0) begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Digit store write port.
	always_ff @(posedge clk) begin
		if (accept && is_digit && cnt_q < CNT_MAX) begin
			mem[cnt_q[IDX_W-1:0]] <= key_digit;
		end
	end

	// Digit store registered read port, held in range past the last digit.
	assign rd_addr = (rd_idx_q < CNT_MAX) ? rd_idx_q[IDX_W-1:0] : '0;

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
	end

	// Sequencer for the conversion walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			len_q    <= '0;
			rd_idx_q <= '0;
			num_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start_conv) begin
						len_q    <= cnt_q;
						rd_idx_q <= '0;
						state_q  <= S_PRIME;
					end
				end
				S_PRIME: begin
					rd_idx_q <= rd_idx_q + 1'b1;
					num_q    <= '0;
					state_q  <= S_CONV;
				end
				S_CONV: begin
					if (rd_idx_q < len_q) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					num_q <= num_q + 1'b1;
					if (num_q == len_q - 1'b1) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Accumulator control.
	always_comb begin
		conv_ctl.clear = start_conv;
		conv_ctl.step  = (state_q == S_CONV);
		conv_ctl.first = (num_q == '0);
	end

	dpe_conv u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (conv_ctl),
		.digit  (rd_q),
		.acc    (conv_acc),
		.bad    (conv_bad)
	);

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if ((accept && !start_conv) || (state_q == S_DONE && out_free)) begin
			out_v_q <= 1'b1;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			echo_q   <= ECHO_NONE;
			done_q   <= 1'b1;
			pvalid_q <= !conv_bad;
			value_q  <= conv_bad ? '0 : conv_acc;
		end else if (accept && !start_conv) begin
			echo_q   <= ECHO_NONE;
			done_q   <= is_term;
			pvalid_q <= 1'b0;
			value_q  <= '0;
			if (is_digit && cnt_q < CNT_MAX && echo_en_q) begin
				echo_q <= ECHO_MASK;
			end else if (is_bs && ovf_q == '0 && cnt_q != '0 && echo_en_q) begin
				echo_q <= ECHO_ERASE;
			end
		end
	end

	assign out_valid   = out_v_q;
	assign echo_action = echo_q;
	assign entry_done  = done_q;
	assign pin_valid   = pvalid_q;
	assign pin_value   = value_q;

	// A valid PIN only comes with the beat that ends the entry.
	a_valid_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pin_valid |-> entry_done)
		else $error("pin_valid without entry_done");

	// The beat that ends an entry carries no echo.
	a_done_no_echo: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && entry_done |-> echo_action == ECHO_NONE)
		else $error("echo on terminating beat");

	// An invalid entry reports a zero value.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pin_valid |-> pin_value == '0)
		else $error("nonzero value on invalid entry");

	// No input is taken while a conversion is under way.
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !in_ready)
		else $error("input ready during conversion");

	// Starting a conversion clears the counts for the next entry.
	a_clear_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		start_conv |=> cnt_q == '0 && ovf_q == '0 && state_q == S_PRIME)
		else $error("counts not cleared at conversion start");

endmodule

// ===== hw/rtl/dpe_conv.sv =====
// Multiply-by-ten accumulator that folds in one decimal digit per cycle while step is set.
`timescale 1ns / 1ps

module dpe_conv
	import dpe_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  dpe_conv_ctl_t       ctl,
	input  logic [DIGIT_W-1:0]  digit,
	output logic [VALUE_W-1:0]  acc,
	output logic                bad
);

	localparam int SUM_W = VALUE_W + 4;

	logic [VALUE_W-1:0] acc_q;
	logic               bad_q;
	logic [SUM_W-1:0]   acc_ext;
	logic [SUM_W-1:0]   sum;

	// acc * 10 + digit as two shifted copies and the digit, four bits of headroom.
	always_comb begin
		acc_ext = {4'b0, acc_q};
		sum = (acc_ext << 3) + (acc_ext << 1) + {{(SUM_W - DIGIT_W){1'b0}}, digit};
	end

	// A leading zero or a carry out of 64 bits marks the entry bad until the next clear.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bad_q <= 1'b0;
		end else if (ctl.clear) begin
			bad_q <= 1'b0;
		end else if (ctl.step) begin
			if ((ctl.first && digit == '0) || sum[SUM_W-1:VALUE_W] != '0) begin
				bad_q <= 1'b1;
			end
		end
	end

	// The accumulator itself is payload and needs no reset.
	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			acc_q <= '0;
		end else if (ctl.step) begin
			acc_q <= sum[VALUE_W-1:0];
		end
	end

	assign acc = acc_q;
	assign bad = bad_q;

endmodule

// ===== test/tb_decimal_pin_entry_top.sv =====
// Self-checking testbench for decimal_pin_entry_top with a keystroke predictor and scoreboard.
`timescale 1ns / 1ps

// One result beat as the block presents it.
typedef struct packed {
	logic [1:0]                  echo;
	logic                        done;
	logic                        valid;
	logic [dpe_pkg::VALUE_W-1:0] value;
} pin_result_t;

// Tracks the entry state of the block and holds the results still owed by it.
class pin_entry_scoreboard;
	localparam int MAX_DIGITS = 20;
	localparam int OVER_MAX   = 65535;

	bit          echo_on;
	logic [3:0]  digits [MAX_DIGITS];
	int unsigned n_digits;
	int unsigned n_over;
	pin_result_t awaited[$];
	int unsigned mismatches;

	function new();
		echo_on    = 1'b1;
		n_digits   = 0;
		n_over     = 0;
		mismatches = 0;
	endfunction

	// Applies one accepted keystroke to the entry state and queues its result.
	function void note_keystroke(logic [7:0] key, logic eoi);
		pin_result_t r;
		logic [63:0] acc;
		logic [63:0] d;
		bit          ok;
		int unsigned i;
		r = '0;
		if (eoi || key == dpe_pkg::KEY_LF || key == dpe_pkg::KEY_CR) begin
			// The entry ends: fold the digits in, stopping when the next one would not fit.
			r.done = 1'b1;
			ok = (n_digits != 0) && (n_over == 0) && (digits[0] != 4'd0);
			acc = '0;
			for (i = 0; ok && i < n_digits; i++) begin
				d = 64'(digits[i]);
				if (acc > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10)
					ok = 1'b0;
				else
					acc = acc * 64'd10 + d;
			end
			r.valid = ok;
			r.value = ok ? acc : 64'd0;
			n_digits = 0;
			n_over   = 0;
		end else if (key >= dpe_pkg::KEY_ZERO && key <= dpe_pkg::KEY_NINE) begin
			if (n_digits >= MAX_DIGITS) begin
				if (n_over < OVER_MAX)
					n_over++;
			end else begin
				digits[n_digits] = 4'(key - dpe_pkg::KEY_ZERO);
				n_digits++;
				if (echo_on)
					r.echo = dpe_pkg::ECHO_MASK;
			end
		end else if (key == dpe_pkg::KEY_BS || key == dpe_pkg::KEY_DEL) begin
			// Over-limit digits go first and are erased silently.
			if (n_over > 0) begin
				n_over--;
			end else if (n_digits > 0) begin
				n_digits--;
				if (echo_on)
					r.echo = dpe_pkg::ECHO_ERASE;
			end
		end
		awaited.insert(awaited.size(), r);
	endfunction

	// Compares one accepted result beat with the oldest expectation.
	function void check_result(pin_result_t got);
		pin_result_t want;
		if (awaited.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: unexpected result echo=%0d done=%0d valid=%0d value=%0d",
					$realtime, got.echo, got.done, got.valid, got.value);
		end else begin
			want = awaited.pop_front();
			if (got.echo !== want.echo || got.done !== want.done ||
					got.valid !== want.valid || got.value !== want.value) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"%0t: result mismatch: expected echo=%0d done=%0d valid=%0d ",
						"value=%0d, got echo=%0d done=%0d valid=%0d value=%0d"}, $realtime,
						want.echo, want.done, want.valid, want.value,
						got.echo, got.done, got.valid, got.value);
			end
		end
	endfunction

	// Results never delivered count as failures.
	function void flag_leftovers();
		if (awaited.size() != 0) begin
			mismatches += awaited.size();
			$display("%0t: %0d expected results never arrived", $realtime, awaited.size());
		end
	endfunction
endclass

module tb_decimal_pin_entry_top;
	import dpe_pkg::*;

	localparam int MAX_DIGITS = 20;
	localparam int OVF_BITS   = 16;
	localparam int PHASE_KEYS = 445;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               cfg_we       = 1'b0;
	logic               cfg_wdata    = 1'b0;
	logic               in_valid     = 1'b0;
	logic               in_ready;
	logic [7:0]         key_byte     = 8'd0;
	logic               end_of_input = 1'b0;
	logic               out_valid;
	logic               out_ready    = 1'b0;
	logic [1:0]         echo_action;
	logic               entry_done;
	logic               pin_valid;
	logic [VALUE_W-1:0] pin_value;

	pin_entry_scoreboard scoreboard = new();
	int unsigned         send_idle_pct = 0;
	int unsigned         recv_stall_pct = 0;
	int unsigned         hold_requests = 0;
	int unsigned         keys_sent = 0;

	decimal_pin_entry_top #(
		.MAX_DIGITS          (MAX_DIGITS),
		.OVERFLOW_COUNT_BITS (OVF_BITS)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.key_byte     (key_byte),
		.end_of_input (end_of_input),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.echo_action  (echo_action),
		.entry_done   (entry_done),
		.pin_valid    (pin_valid),
		.pin_value    (pin_value)
	);

	always #5 clk = ~clk;

	// Output side: check every accepted beat, then pick the next ready level.
	initial begin
		int unsigned hold_left;
		int unsigned holds_seen;
		hold_left  = 0;
		holds_seen = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				scoreboard.check_result({echo_action, entry_done, pin_valid, pin_value});
			if (hold_requests != holds_seen) begin
				holds_seen = hold_requests;
				hold_left  = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Ends a run that hangs.
	initial begin
		#50_000_000;
		$display("decimal_pin_entry_top regression: fail");
		$finish;
	end

	task automatic set_idling(idle_mode_e mode);
		case (mode)
			IDLE_NONE: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			IDLE_SENDER: begin
				send_idle_pct  = 52;
				recv_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				send_idle_pct  = 0;
				recv_stall_pct = 52;
			end
			default: begin
				send_idle_pct  = 37;
				recv_stall_pct = 37;
			end
		endcase
	endtask

	// Writes echo_enable; the block must be idle.
	task automatic write_echo(logic on);
		cfg_we    <= 1'b1;
		cfg_wdata <= on;
		@(posedge clk);
		cfg_we <= 1'b0;
		scoreboard.echo_on = on;
	endtask

	// Drops the input, waits until every result has come back, then idles long enough for a
	// conversion to finish.
	task automatic settle();
		in_valid <= 1'b0;
		while (scoreboard.awaited.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// Offers one input beat, with a random gap first, and holds it until accepted.
	task automatic send_key(logic [7:0] key, logic eoi);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		key_byte     <= key;
		end_of_input <= eoi;
		do
			@(posedge clk);
		while (!in_ready);
		scoreboard.note_keystroke(key, eoi);
		if (eoi || key == KEY_LF || key == KEY_CR || key == KEY_BS || key == KEY_DEL ||
				(key >= KEY_ZERO && key <= KEY_NINE))
			keys_sent++;
	endtask

	function automatic logic [7:0] any_digit();
		return 8'(KEY_ZERO + $urandom_range(9));
	endfunction

	task automatic send_terminator();
		case ($urandom_range(2))
			0:       send_key(KEY_LF, 1'b0);
			1:       send_key(KEY_CR, 1'b0);
			default: send_key(8'($urandom_range(255)), 1'b1);
		endcase
	endtask

	// One random entry: mostly well-formed digit strings with edits, some near 2^64-1,
	// some raw noise.
	task automatic send_entry();
		string       max_txt;
		int unsigned shape;
		int unsigned len;
		int unsigned tail;
		int unsigned i;
		logic [7:0]  ch;
		max_txt = "18446744073709551615";
		shape   = $urandom_range(99);
		if (shape < 12) begin
			repeat ($urandom_range(1, 4))
				send_key(8'($urandom_range(255)), $urandom_range(9) == 0);
		end else if (shape < 24) begin
			// Around the largest value that fits.
			tail = $urandom_range(1, 6);
			shape = $urandom_range(3);
			for (i = 0; i < 20; i++) begin
				ch = max_txt[i];
				if (shape == 1 && i == 19)
					ch = 8'(KEY_ZERO + $urandom_range(6, 9));
				else if (shape == 2 && i >= 20 - tail)
					ch = any_digit();
				else if (shape == 3 && i > 0)
					ch = any_digit();
				send_key(ch, 1'b0);
			end
			send_terminator();
		end else begin
			shape = $urandom_range(99);
			if (shape < 75)
				len = $urandom_range(0, 8);
			else if (shape < 90)
				len = $urandom_range(9, 20);
			else
				len = $urandom_range(21, 24);
			for (i = 0; i < len; i++) begin
				send_key(any_digit(), 1'b0);
				if ($urandom_range(9) == 0)
					send_key($urandom_range(1) ? KEY_BS : KEY_DEL, 1'b0);
				if ($urandom_range(19) == 0)
					send_key(8'($urandom_range(255)), 1'b0);
			end
			send_terminator();
		end
	endtask

	// Main sequence.
	initial begin
		int unsigned guard;
		idle_mode_e  mode;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_echo(1'b1);

		// Directed: empty entries, edits, ignored bytes, digit range edges, leading zero.
		set_idling(IDLE_NONE);
		send_key(8'h31, 1'b1);
		send_key(KEY_BS, 1'b0);
		send_key(8'h31, 1'b0);
		send_key(KEY_ZERO, 1'b0);
		send_key(KEY_DEL, 1'b0);
		send_key(KEY_NINE, 1'b0);
		send_key(8'hFF, 1'b0);
		send_key(8'h00, 1'b0);
		send_key(8'h2F, 1'b0);
		send_key(8'h3A, 1'b0);
		send_key(8'h80, 1'b0);
		send_key(KEY_CR, 1'b0);
		send_key(KEY_ZERO, 1'b0);
		send_key(8'h35, 1'b0);
		send_key(KEY_LF, 1'b0);
		send_key(8'h37, 1'b0);
		send_key(KEY_BS, 1'b1);
		send_key(KEY_LF, 1'b0);
		settle();

		// Random entries under each idling pattern, echo toggled between phases.
		for (int p = 0; p < 4; p++) begin
			mode = idle_mode_e'(p);
			set_idling(mode);
			write_echo(p[0] ? 1'b0 : 1'b1);
			keys_sent = 0;
			while (keys_sent < PHASE_KEYS)
				send_entry();
			settle();
		end

		// Long output hold-off while input keeps coming, so the block backs up.
		set_idling(IDLE_NONE);
		write_echo(1'b1);
		hold_requests++;
		keys_sent = 0;
		while (keys_sent < 60)
			send_entry();
		settle();

		// Fill the store, type past the limit, unwind the extra digits, then erase a stored one.
		write_echo(1'b0);
		write_echo(1'b1);
		send_key(8'(KEY_ZERO + $urandom_range(1, 9)), 1'b0);
		repeat (MAX_DIGITS - 1) send_key(any_digit(), 1'b0);
		repeat (6) send_key(any_digit(), 1'b0);
		repeat (6) send_key($urandom_range(1) ? KEY_BS : KEY_DEL, 1'b0);
		send_key(KEY_BS, 1'b0);
		send_key(KEY_LF, 1'b0);

		// Drain and report.
		in_valid <= 1'b0;
		guard = 0;
		while (scoreboard.awaited.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (40) @(posedge clk);
		scoreboard.flag_leftovers();
		if (scoreboard.mismatches == 0)
			$display("decimal_pin_entry_top regression: pass");
		else
			$display("decimal_pin_entry_top regression: fail");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/dpe_pkg.sv
hw/rtl/dpe_conv.sv
hw/rtl/decimal_pin_entry_top.sv
test/tb_decimal_pin_entry_top.sv
